// ===== hdl/rbsi_pkg.sv =====
package rbsi_pkg;

  localparam int unsigned CRD_W  = 32;
  localparam int unsigned DIF_W  = CRD_W + 1;
  localparam int unsigned SUM_W  = CRD_W + 2;
  localparam int unsigned EXT_W  = 31;
  localparam int unsigned TOL_W  = 16;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned NUM_W  = DIF_W;
  localparam int unsigned REM_W  = NUM_W + 1;
  localparam int unsigned QUO_W  = FRAC_W;
  localparam int unsigned PRD_W  = FRAC_W + 1 + DIF_W;
  localparam int unsigned NAXES  = 3;
  localparam int unsigned IN_W   = 6 * CRD_W;
  localparam int unsigned OUT_W  = 120;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);
  localparam logic [PRD_W-1:0]  RND_Q16 = PRD_W'(65535);

  typedef enum logic [1:0] {
    CFG_HALF_X = 2'd0,
    CFG_HALF_Y = 2'd1,
    CFG_HALF_Z = 2'd2,
    CFG_TOL    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

// ===== hdl/rbsi_div.sv =====
module rbsi_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rbsi_pkg::NUM_W-1:0] num_i,
  input  logic [rbsi_pkg::NUM_W-1:0] den_i,
  output logic [rbsi_pkg::QUO_W-1:0] quo_o
);
  import rbsi_pkg::*;

  logic [REM_W-1:0] rem_q   [QUO_W];
  logic [REM_W-1:0] rem_d   [QUO_W];
  logic [NUM_W-1:0] den_q   [QUO_W];
  logic [QUO_W-1:0] quo_q   [QUO_W];
  logic [QUO_W-1:0] quo_d   [QUO_W];
  logic [REM_W-1:0] trial   [QUO_W];
  logic [REM_W-1:0] dsel    [QUO_W];

  always_comb begin
    trial[0] = REM_W'(num_i);
    dsel[0]  = REM_W'(den_i);
    for (int k = 1; k < QUO_W; k++) begin
      trial[k] = {rem_q[k-1][REM_W-2:0], 1'b0};
      dsel[k]  = REM_W'(den_q[k-1]);
    end
    for (int k = 0; k < QUO_W; k++) begin
      if (trial[k] >= dsel[k]) begin
        rem_d[k] = trial[k] - dsel[k];
      end else begin
        rem_d[k] = trial[k];
      end
    end
    quo_d[0] = QUO_W'(trial[0] >= dsel[0]);
    for (int k = 1; k < QUO_W; k++) begin
      quo_d[k] = {quo_q[k-1][QUO_W-2:0], trial[k] >= dsel[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      for (int k = 1; k < QUO_W; k++) begin
        den_q[k] <= den_q[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// Segment versus origin-centered box test by the slab method, Q16.16 fixed point. One segment
// is taken per clock, and the pipeline is made of the 17-stage restoring dividers (one quotient
// bit per stage) that produce the entry and exit fractions on each axis, plus input, setup,
// face-select, multiply and output stages. The whole pipeline holds while a result waits on
// m_axis_tready. Write the configuration registers only while no segment is in flight.
module ray_box_slab_intersect (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [30:0]                 cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // start_x, start_y, start_z, stop_x, stop_y, stop_z
  input  logic [rbsi_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit_found, face_axis, normal_negative, hit_x, hit_y, hit_z, hit_fraction, zero fill
  output logic [rbsi_pkg::OUT_W-1:0]  m_axis_tdata
);
  import rbsi_pkg::*;

  typedef struct packed {
    logic signed [CRD_W-1:0] s;
    logic signed [DIF_W-1:0] d;
    logic                    par;
    logic                    in_slab;
    logic                    neg_e;
    logic                    neg_l;
    logic                    ovf_e;
    logic                    ovf_l;
  } side_t;

  logic [EXT_W-1:0] half_q [NAXES];
  logic [TOL_W-1:0] tol_q;
  logic             en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= EXT_W'(65536);
      half_q[1] <= EXT_W'(65536);
      half_q[2] <= EXT_W'(65536);
      tol_q     <= TOL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_X: half_q[0] <= cfg_data_i;
        CFG_HALF_Y: half_q[1] <= cfg_data_i;
        CFG_HALF_Z: half_q[2] <= cfg_data_i;
        CFG_TOL:    tol_q     <= cfg_data_i[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage A: offsets
  logic                    va_q;
  logic signed [CRD_W-1:0] sa_q [NAXES];
  logic signed [DIF_W-1:0] da_q [NAXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NAXES; i++) begin
        sa_q[i] <= $signed(s_axis_tdata[i*CRD_W +: CRD_W]);
        da_q[i] <= $signed({s_axis_tdata[(i+3)*CRD_W + CRD_W-1], s_axis_tdata[(i+3)*CRD_W +: CRD_W]})
                 - $signed({s_axis_tdata[i*CRD_W + CRD_W-1], s_axis_tdata[i*CRD_W +: CRD_W]});
      end
    end
  end

  // stage B: slab numerators, parallel and in-slab flags
  logic signed [SUM_W-1:0] hb     [NAXES];
  logic signed [SUM_W-1:0] sb     [NAXES];
  logic signed [SUM_W-1:0] pos_n  [NAXES];
  logic signed [SUM_W-1:0] neg_n  [NAXES];
  logic signed [SUM_W-1:0] num_e  [NAXES];
  logic signed [SUM_W-1:0] num_l  [NAXES];
  logic [NUM_W-1:0]        mag_e  [NAXES];
  logic [NUM_W-1:0]        mag_l  [NAXES];
  logic [NUM_W-1:0]        ad     [NAXES];
  side_t                   side_b [NAXES];

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      hb[i]    = $signed({3'b000, half_q[i]});
      sb[i]    = SUM_W'(sa_q[i]);
      neg_n[i] = -(hb[i] + sb[i]);
      pos_n[i] = hb[i] - sb[i];
      ad[i]    = da_q[i][DIF_W-1] ? NUM_W'(-da_q[i]) : NUM_W'(da_q[i]);
      if (!da_q[i][DIF_W-1]) begin
        num_e[i] = neg_n[i];
        num_l[i] = pos_n[i];
      end else begin
        num_e[i] = pos_n[i];
        num_l[i] = neg_n[i];
      end
      mag_e[i] = num_e[i][SUM_W-1] ? NUM_W'(-num_e[i]) : NUM_W'(num_e[i]);
      mag_l[i] = num_l[i][SUM_W-1] ? NUM_W'(-num_l[i]) : NUM_W'(num_l[i]);
      side_b[i].s       = sa_q[i];
      side_b[i].d       = da_q[i];
      side_b[i].par     = (da_q[i] == '0) || (ad[i] < NUM_W'(tol_q));
      side_b[i].in_slab = (sb[i] > -hb[i]) && (sb[i] < hb[i]);
      side_b[i].neg_e   = num_e[i][SUM_W-1] ^ da_q[i][DIF_W-1];
      side_b[i].neg_l   = num_l[i][SUM_W-1] ^ da_q[i][DIF_W-1];
      side_b[i].ovf_e   = REM_W'(mag_e[i]) >= {ad[i], 1'b0};
      side_b[i].ovf_l   = REM_W'(mag_l[i]) >= {ad[i], 1'b0};
    end
  end

  logic             vb_q;
  side_t            sdb_q  [NAXES];
  logic [NUM_W-1:0] nme_q  [NAXES];
  logic [NUM_W-1:0] nml_q  [NAXES];
  logic [NUM_W-1:0] den_q  [NAXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NAXES; i++) begin
        sdb_q[i] <= side_b[i];
        nme_q[i] <= mag_e[i];
        nml_q[i] <= mag_l[i];
        den_q[i] <= ad[i];
      end
    end
  end

  // divider stages
  logic [QUO_W-1:0] qe [NAXES];
  logic [QUO_W-1:0] ql [NAXES];

  for (genvar g = 0; g < NAXES; g++) begin : g_div
    rbsi_div u_div_e (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nme_q[g]),
      .den_i (den_q[g]),
      .quo_o (qe[g])
    );
    rbsi_div u_div_l (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nml_q[g]),
      .den_i (den_q[g]),
      .quo_o (ql[g])
    );
  end

  logic [QUO_W-1:0] vdly_q;
  side_t            sdly_q [QUO_W][NAXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdly_q <= '0;
    end else if (en) begin
      vdly_q <= {vdly_q[QUO_W-2:0], vb_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdly_q[0] <= sdb_q;
      for (int k = 1; k < QUO_W; k++) begin
        sdly_q[k] <= sdly_q[k-1];
      end
    end
  end

  // stage E: clamp fractions, pick face
  side_t             sx    [NAXES];
  logic [FRAC_W-1:0] enter [NAXES];
  logic [FRAC_W-1:0] leave [NAXES];
  logic [NAXES-1:0]  ok;
  logic [FRAC_W-1:0] best;
  logic [FRAC_W-1:0] worst;
  axis_e             face;
  logic              hit_e;
  logic              nneg_e;

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      sx[i] = sdly_q[QUO_W-1][i];
      if (sx[i].par) begin
        enter[i] = '0;
        leave[i] = ONE_Q16;
        ok[i]    = sx[i].in_slab;
      end else begin
        enter[i] = sx[i].neg_e ? '0 : qe[i];
        if (sx[i].ovf_l || ql[i] > ONE_Q16) begin
          leave[i] = ONE_Q16;
        end else begin
          leave[i] = ql[i];
        end
        ok[i] = !(!sx[i].neg_e && (sx[i].ovf_e || qe[i] >= ONE_Q16))
              && !sx[i].neg_l && (ql[i] != '0);
      end
    end
    best  = enter[0];
    worst = leave[0];
    face  = AXIS_X;
    if (enter[1] > best) begin
      best = enter[1];
      face = AXIS_Y;
    end
    if (leave[1] < worst) worst = leave[1];
    if (enter[2] > best) begin
      best = enter[2];
      face = AXIS_Z;
    end
    if (leave[2] < worst) worst = leave[2];
    hit_e = (&ok) && (best <= worst) && (best > FRAC_W'(tol_q));
    unique case (face)
      AXIS_X:  nneg_e = !sx[0].d[DIF_W-1] && (sx[0].d != '0);
      AXIS_Y:  nneg_e = !sx[1].d[DIF_W-1] && (sx[1].d != '0);
      AXIS_Z:  nneg_e = !sx[2].d[DIF_W-1] && (sx[2].d != '0);
      default: nneg_e = 1'b0;
    endcase
  end

  logic                    ve_q;
  logic                    hit_e_q;
  logic [FRAC_W-1:0]       best_e_q;
  axis_e                   face_e_q;
  logic                    nneg_e_q;
  logic signed [CRD_W-1:0] se_q [NAXES];
  logic signed [DIF_W-1:0] de_q [NAXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= vdly_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_e_q  <= hit_e;
      best_e_q <= best;
      face_e_q <= face;
      nneg_e_q <= nneg_e;
      for (int i = 0; i < NAXES; i++) begin
        se_q[i] <= sx[i].s;
        de_q[i] <= sx[i].d;
      end
    end
  end

  // stage F: fraction times offset
  logic                    vf_q;
  logic                    hit_f_q;
  logic [FRAC_W-1:0]       best_f_q;
  axis_e                   face_f_q;
  logic                    nneg_f_q;
  logic signed [CRD_W-1:0] sf_q [NAXES];
  logic signed [PRD_W-1:0] pf_q [NAXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_f_q  <= hit_e_q;
      best_f_q <= best_e_q;
      face_f_q <= face_e_q;
      nneg_f_q <= nneg_e_q;
      for (int i = 0; i < NAXES; i++) begin
        sf_q[i] <= se_q[i];
        pf_q[i] <= $signed({1'b0, best_e_q}) * de_q[i];
      end
    end
  end

  // stage G: hit point and output register
  logic signed [PRD_W-1:0] biased [NAXES];
  logic signed [PRD_W-1:0] scaled [NAXES];
  logic [CRD_W-1:0]        pnt    [NAXES];

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      biased[i] = pf_q[i] + (pf_q[i][PRD_W-1] ? $signed(RND_Q16) : $signed(PRD_W'(0)));
      scaled[i] = biased[i] >>> 16;
      pnt[i]    = sf_q[i] + scaled[i][CRD_W-1:0];
    end
  end

  logic              vg_q;
  logic              hit_q;
  logic [1:0]        face_q;
  logic              nneg_q;
  logic [CRD_W-1:0]  pnt_q [NAXES];
  logic [FRAC_W-1:0] frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_f_q;
      face_q <= hit_f_q ? face_f_q : 2'b00;
      nneg_q <= hit_f_q && nneg_f_q;
      frac_q <= hit_f_q ? best_f_q : '0;
      for (int i = 0; i < NAXES; i++) begin
        pnt_q[i] <= hit_f_q ? pnt[i] : '0;
      end
    end
  end

  assign m_axis_tvalid = vg_q;
  assign m_axis_tdata  = {3'b000, frac_q, pnt_q[2], pnt_q[1], pnt_q[0], nneg_q, face_q, hit_q};

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vg_q && !hit_q |-> frac_q == '0 && face_q == 2'b00 && !nneg_q)
    else $error("miss result carries nonzero fields");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vg_q && hit_q |-> frac_q != '0 && frac_q <= ONE_Q16)
    else $error("hit fraction out of range");

  a_face_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vg_q && hit_q |-> face_q != 2'b11)
    else $error("face axis out of range");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> va_q)
    else $error("accepted segment lost at pipeline entry");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rbsi_pkg::*;

  localparam int unsigned LIMIT = 600000;
  localparam int unsigned FLUSH = 30;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint CMAX = 64'sd2147483647;

  class slab_scoreboard;
    longint half[3];
    longint tol;
    bit [OUT_W-1:0] pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;

    function void set_default();
      half = '{65536, 65536, 65536};
      tol = 1;
    endfunction

    function bit cut_axis(longint s, longint d, longint h,
                          output longint lo, output longint hi);
      longint ad, t1, t2, tmp;
      ad = d < 0 ? -d : d;
      lo = 0;
      hi = 65536;
      if (d == 0 || ad < tol) return (s > -h && s < h);
      t1 = (-(h + s) * 65536) / d;
      t2 = ((h - s) * 65536) / d;
      if (t1 > t2) begin
        tmp = t1;
        t1 = t2;
        t2 = tmp;
      end
      if (t1 > 0) lo = t1;
      if (t2 < 65536) hi = t2;
      return lo < 65536 && hi > 0;
    endfunction

    function void note(bit [IN_W-1:0] seg);
      longint s[3], d[3], lo[3], hi[3];
      longint best, worst, p;
      bit ok;
      axis_e face;
      bit [OUT_W-1:0] r;
      ok = 1;
      r = '0;
      face = AXIS_X;
      for (int i = 0; i < 3; i++) begin
        s[i] = longint'($signed(seg[32*i +: 32]));
        d[i] = longint'($signed(seg[32*(i+3) +: 32])) - s[i];
        if (!cut_axis(s[i], d[i], half[i], lo[i], hi[i])) ok = 0;
      end
      if (ok) begin
        best = lo[0];
        worst = hi[0];
        for (int i = 1; i < 3; i++) begin
          if (lo[i] > best) begin
            best = lo[i];
            face = axis_e'(i);
          end
          if (hi[i] < worst) worst = hi[i];
        end
        if (best <= worst && best > tol) begin
          r[0] = 1'b1;
          r[2:1] = face;
          r[3] = d[face] > 0;
          for (int i = 0; i < 3; i++) begin
            p = s[i] + (best * d[i]) / 65536;
            r[4 + 32*i +: 32] = p[31:0];
          end
          r[116:100] = best[16:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check(bit [OUT_W-1:0] y);
      bit [OUT_W-1:0] e;
      int lsb[7] = '{0, 1, 3, 4, 36, 68, 100};
      int wid[7] = '{1, 2, 1, 32, 32, 32, 17};
      string nm[7] = '{"hit_found", "face_axis", "normal_negative", "hit_x", "hit_y",
                       "hit_z", "hit_fraction"};
      bit [31:0] ev, av;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", y);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e[0]) hits++;
      for (int f = 0; f < 7; f++) begin
        ev = 32'((e >> lsb[f]) & ((OUT_W'(1) << wid[f]) - 1));
        av = 32'((y >> lsb[f]) & ((OUT_W'(1) << wid[f]) - 1));
        if (ev !== av) begin
          $error("%s mismatch: expected %h, got %h", nm[f], ev, av);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  slab_scoreboard sb = new();
  bit stall_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned phase_cnt = 0;

  ray_box_slab_intersect uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_en && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[30:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TOL) sb.tol = val & 16'hffff;
    else sb.half[idx] = val & 31'h7fffffff;
  endtask

  task automatic send_segment(bit [IN_W-1:0] seg);
    if (stall_en && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= seg;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(seg);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (FLUSH) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic bit [31:0] clamp32(longint v);
    if (v > CMAX) return 32'h7fffffff;
    if (v < CMIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint pick(longint span);
    longint u;
    u = longint'({$urandom, $urandom} & 64'h3fffffffffffffff);
    return (u % (2 * span + 1)) - span;
  endfunction

  function automatic bit [IN_W-1:0] seg_of(longint c[6]);
    bit [IN_W-1:0] r;
    for (int i = 0; i < 6; i++) r[32*i +: 32] = clamp32(c[i]);
    return r;
  endfunction

  function automatic bit [IN_W-1:0] random_segment();
    longint c[6];
    longint span;
    int unsigned mode;
    bit [IN_W-1:0] r;
    mode = $urandom_range(99);
    if (mode < 20) begin
      for (int i = 0; i < 6; i++) r[32*i +: 32] = $urandom;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      span = 2 * sb.half[i] + 65536;
      c[i] = pick(span);
      c[i+3] = pick(span);
    end
    if (mode >= 80) begin
      int unsigned a;
      a = $urandom_range(2);
      c[a+3] = c[a] + pick(sb.tol + 1);
    end else if (mode >= 50) begin
      int unsigned a;
      a = $urandom_range(2);
      c[a] = ($urandom_range(1) ? 1 : -1) * (sb.half[a] + $urandom_range(65536));
      c[a+3] = -c[a] / 2 + pick(sb.half[a] / 2 + 1);
    end
    return seg_of(c);
  endfunction

  task automatic directed_run();
    longint h;
    h = 65536;
    send_segment(seg_of('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}));
    send_segment(seg_of('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}));
    send_segment(seg_of('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}));
    send_segment(seg_of('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}));
    for (int a = 0; a < 3; a++) begin
      longint c[6];
      c = '{0, 0, 0, 0, 0, 0};
      c[a] = -3 * h; c[a+3] = 3 * h;
      send_segment(seg_of(c));
      c[a] = 3 * h; c[a+3] = -3 * h;
      send_segment(seg_of(c));
    end
    send_segment(seg_of('{0, 0, 0, 3 * h, 0, 0}));
    send_segment(seg_of('{-3 * h, 2 * h, 0, 3 * h, 2 * h, 0}));
    send_segment(seg_of('{-3 * h, h, 0, 3 * h, h, 0}));
    send_segment(seg_of('{-3 * h, 0, 0, -h, 0, 0}));
    send_segment(seg_of('{-3 * h, -3 * h, -3 * h, 3 * h, 3 * h, 3 * h}));
    send_segment(seg_of('{5 * h, 0, 0, 5 * h, 0, 0}));
    send_segment(seg_of('{-2 * h, 0, 0, -2 * h + 1, 3 * h, 0}));
    send_segment(seg_of('{-h - 1, 0, 0, 2 * h, 0, 0}));
    send_segment(seg_of('{-3 * h, 0, 0, 3 * h, 0, 1}));
  endtask

  task automatic phase(longint hx, longint hy, longint hz, longint t, int n);
    write_reg(CFG_HALF_X, hx);
    write_reg(CFG_HALF_Y, hy);
    write_reg(CFG_HALF_Z, hz);
    write_reg(CFG_TOL, t);
    repeat (n) send_segment(random_segment());
    drain();
    phase_cnt++;
  endtask

  initial begin
    sb.set_default();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_run();
    repeat (120) send_segment(random_segment());
    drain();
    phase(2147483647, 2147483647, 2147483647, 65535, 250);
    phase(0, 0, 0, 0, 150);
    phase(256, 65536, 1 << 20, 0, 250);
    phase(3 << 16, 1 << 24, 100, 65535, 250);
    for (int k = 0; k < 3; k++)
      phase($urandom_range(1 << 24), $urandom_range(1 << 24), $urandom_range(1 << 24),
            $urandom_range(65535), 250);
    stall_en = 1'b0;
    phase(65536, 65536, 65536, 1, 250);
    $display("Checked %0d segment results (%0d hits) over %0d register settings.",
             sb.checked, sb.hits, phase_cnt + 1);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rbsi_pkg.sv
hdl/rbsi_div.sv
hdl/ray_box_slab_intersect.sv
tb/tb.sv
